[sv/tlbt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the TLB / LRU page translator.
// Used by tlbt_rank_cell and tlb_lru_page_translator; depends on nothing.
package tlbt_pkg;

	// Defaults for the top-level parameters
	localparam int PAGE_COUNT_DEF  = 256;
	localparam int TLB_ENTRIES_DEF = 16;
	localparam int MAX_FRAMES_DEF  = 256;
	localparam int OFFSET_BITS_DEF = 8;

	// Fixed field widths of the stream words
	localparam int VA_W      = 16;
	localparam int OUT_FR_W  = 8;
	localparam int OUT_PG_W  = 8;
	localparam int NUMFR_W   = 9;
	localparam int MIN_FRAMES = 16;
	localparam int OUT_DATA_W = 40;

	// Command word widths cover the largest parameter values
	localparam int CMD_FRAME_W = 10;
	localparam int CMD_PAGE_W  = 12;
	localparam int CMD_USED_W  = 11;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_RANK,
		ST_UPD
	} state_t;

	// Recency update broadcast to every rank cell
	typedef struct packed {
		logic                   push;   // hand out a new frame at index used
		logic                   touch;  // make frame the most recent
		logic                   own;    // load owner page into the frame's cell
		logic [CMD_FRAME_W-1:0] frame;
		logic [CMD_FRAME_W-1:0] rank;   // old rank of the touched frame
		logic [CMD_PAGE_W-1:0]  page;
		logic [CMD_USED_W-1:0]  used;   // frames in use before this update
	} rank_cmd_t;

endpackage

[sv/tlbt_rank_cell.sv]
`timescale 1ns / 1ps
// One frame's recency cell: holds the frame's rank (0 = most recent) and owner page.
// Depends on tlbt_pkg for the broadcast command type.
module tlbt_rank_cell #(
	parameter int INDEX   = 0,
	parameter int FRAME_W = 8,
	parameter int PAGE_W  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlbt_pkg::rank_cmd_t  cmd,
	output logic [FRAME_W-1:0]   rank,
	output logic [PAGE_W-1:0]    owner
);

	logic [FRAME_W-1:0] rank_q;
	logic [PAGE_W-1:0]  owner_q;
	logic               in_use;
	logic               is_me;
	logic               is_next;

	assign in_use  = tlbt_pkg::CMD_USED_W'(INDEX) < cmd.used;
	assign is_me   = cmd.frame == tlbt_pkg::CMD_FRAME_W'(INDEX);
	assign is_next = cmd.used == tlbt_pkg::CMD_USED_W'(INDEX);

	// Age or refresh the rank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (cmd.push) begin
			if (is_next)
				rank_q <= '0;
			else if (in_use)
				rank_q <= rank_q + 1'b1;
		end else if (cmd.touch) begin
			if (is_me)
				rank_q <= '0;
			else if (in_use && (tlbt_pkg::CMD_FRAME_W'(rank_q) < cmd.rank))
				rank_q <= rank_q + 1'b1;
		end
	end

	// Record the resident page
	always_ff @(posedge clk) begin
		if ((cmd.push && is_next) || (cmd.own && is_me))
			owner_q <= cmd.page[PAGE_W-1:0];
	end

	assign rank  = rank_q;
	assign owner = owner_q;

endmodule

[sv/tlb_lru_page_translator.sv]
`timescale 1ns / 1ps
// Top level: FIFO-refilled TLB, page map and a row of LRU rank cells.
// Depends on tlbt_pkg and tlbt_rank_cell.
//
// Each word goes through these steps from acceptance to a loaded result register:
// search the TLB and read the page map, pick the frame (free or LRU victim),
// read the touched frame's rank, then age the rank row and load the result.
// A new word is taken only once the previous result has been loaded; the
// result register frees the input side while the result waits downstream.
// The frame count register (cfg_data) is always ready.
module tlb_lru_page_translator #(
	parameter int PAGE_COUNT  = tlbt_pkg::PAGE_COUNT_DEF,
	parameter int TLB_ENTRIES = tlbt_pkg::TLB_ENTRIES_DEF,
	parameter int MAX_FRAMES  = tlbt_pkg::MAX_FRAMES_DEF,
	parameter int OFFSET_BITS = tlbt_pkg::OFFSET_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tlbt_pkg::NUMFR_W-1:0]      cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [15:0] virtual_address
	input  logic [tlbt_pkg::VA_W-1:0]         s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] frame_number, [23:8] physical_address, [24] tlb_hit, [25] page_fault,
	// [26] evicted_valid, [34:27] evicted_page, [39:35] zero
	output logic [tlbt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	localparam int PAGE_W = $clog2(PAGE_COUNT);
	localparam int FRAME_W = $clog2(MAX_FRAMES);
	localparam int USED_W = $clog2(MAX_FRAMES + 1);
	localparam int TLB_W = $clog2(TLB_ENTRIES);

	tlbt_pkg::state_t state_q, state_d;

	logic [tlbt_pkg::NUMFR_W-1:0] num_frames_q;
	logic [USED_W-1:0]            used_q;

	logic [PAGE_W-1:0]  tag_q [TLB_ENTRIES];
	logic [FRAME_W-1:0] tgt_q [TLB_ENTRIES];
	logic [TLB_ENTRIES-1:0] live_q;
	logic [TLB_W-1:0]   fp_q;

	logic [FRAME_W-1:0]    pm_mem [PAGE_COUNT];
	logic [PAGE_COUNT-1:0] pm_valid_q;

	logic [PAGE_W-1:0]      page_s1;
	logic [OFFSET_BITS-1:0] offset_s1;
	logic                   hit_s1;
	logic [FRAME_W-1:0]     tlb_frame_s1;
	logic                   pm_valid_s1;
	logic [FRAME_W-1:0]     pm_frame_s1;

	logic [FRAME_W-1:0] frame_s2;
	logic               fault_s2;
	logic               ev_s2;
	logic               push_s2;
	logic [PAGE_W-1:0]  ev_page_s2;
	logic [FRAME_W-1:0] rank_s3;

	logic                              out_valid_q;
	logic [tlbt_pkg::OUT_DATA_W-1:0]   out_data_q;

	logic [31:0]            va_wide;
	logic [PAGE_W-1:0]      in_page;
	logic                   tlb_found;
	logic [FRAME_W-1:0]     tlb_found_frame;
	logic [FRAME_W-1:0]     rank_v  [MAX_FRAMES];
	logic [PAGE_W-1:0]      owner_v [MAX_FRAMES];
	logic [FRAME_W-1:0]     lru_frame;
	logic [PAGE_W-1:0]      lru_page;
	logic [31:0]            limit;
	logic                   full;
	logic                   accept;
	logic                   commit;
	logic [31:0]            phys_wide;
	tlbt_pkg::rank_cmd_t    cmd;

	assign accept    = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// Split the incoming word
	assign va_wide = 32'(s_axis_tdata) >> OFFSET_BITS;
	assign in_page = va_wide[PAGE_W-1:0];

	// Search the TLB, lowest live entry wins
	always_comb begin
		tlb_found = 1'b0;
		tlb_found_frame = '0;
		for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
			if (live_q[i] && tag_q[i] == in_page) begin
				tlb_found = 1'b1;
				tlb_found_frame = tgt_q[i];
			end
		end
	end

	// Clamp the frame count
	always_comb begin
		limit = 32'(num_frames_q);
		if (limit < 32'(tlbt_pkg::MIN_FRAMES))
			limit = 32'(tlbt_pkg::MIN_FRAMES);
		if (limit > 32'(MAX_FRAMES))
			limit = 32'(MAX_FRAMES);
	end
	assign full = 32'(used_q) >= limit;

	// Locate the least recently used frame: rank equal to used - 1
	always_comb begin
		lru_frame = '0;
		lru_page  = '0;
		for (int g = 0; g < MAX_FRAMES; g++) begin
			if (32'(g) < 32'(used_q) && 32'(rank_v[g]) == 32'(used_q) - 32'd1) begin
				lru_frame = lru_frame | FRAME_W'(g);
				lru_page  = lru_page | owner_v[g];
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		s_axis_tready = 1'b0;
		commit = 1'b0;
		case (state_q)
			tlbt_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = tlbt_pkg::ST_LOOK;
			end
			tlbt_pkg::ST_LOOK: state_d = tlbt_pkg::ST_RANK;
			tlbt_pkg::ST_RANK: state_d = tlbt_pkg::ST_UPD;
			tlbt_pkg::ST_UPD: begin
				if (!out_valid_q || m_axis_tready) begin
					commit = 1'b1;
					state_d = tlbt_pkg::ST_IDLE;
				end
			end
			default: state_d = tlbt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tlbt_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Hold the frame count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			num_frames_q <= tlbt_pkg::NUMFR_W'(256);
		else if (cfg_valid && cfg_ready)
			num_frames_q <= cfg_data;
	end

	// Stage 1: capture lookup results
	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1      <= in_page;
			offset_s1    <= s_axis_tdata[OFFSET_BITS-1:0];
			hit_s1       <= tlb_found;
			tlb_frame_s1 <= tlb_found_frame;
			pm_valid_s1  <= pm_valid_q[in_page];
			pm_frame_s1  <= pm_mem[in_page];
		end
	end

	// Stage 2: pick the frame
	always_ff @(posedge clk) begin
		if (state_q == tlbt_pkg::ST_LOOK) begin
			ev_s2      <= 1'b0;
			push_s2    <= 1'b0;
			fault_s2   <= 1'b0;
			ev_page_s2 <= '0;
			if (hit_s1) begin
				frame_s2 <= tlb_frame_s1;
			end else if (pm_valid_s1) begin
				frame_s2 <= pm_frame_s1;
			end else begin
				fault_s2 <= 1'b1;
				if (full) begin
					frame_s2   <= lru_frame;
					ev_s2      <= 1'b1;
					ev_page_s2 <= lru_page;
				end else begin
					frame_s2 <= used_q[FRAME_W-1:0];
					push_s2  <= 1'b1;
				end
			end
		end
	end

	// Page map: frame data in memory, valid bits in flops
	always_ff @(posedge clk) begin
		if (state_q == tlbt_pkg::ST_LOOK && !hit_s1 && !pm_valid_s1)
			pm_mem[page_s1] <= full ? lru_frame : used_q[FRAME_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_valid_q <= '0;
		end else if (state_q == tlbt_pkg::ST_LOOK && !hit_s1 && !pm_valid_s1) begin
			if (full)
				pm_valid_q[lru_page] <= 1'b0;
			pm_valid_q[page_s1] <= 1'b1;
		end
	end

	// TLB refill in FIFO order, drop entries of an evicted page
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			fp_q   <= '0;
		end else if (state_q == tlbt_pkg::ST_LOOK && !hit_s1) begin
			for (int i = 0; i < TLB_ENTRIES; i++) begin
				if (!pm_valid_s1 && full && tag_q[i] == lru_page)
					live_q[i] <= 1'b0;
			end
			live_q[fp_q] <= 1'b1;
			fp_q <= (32'(fp_q) == TLB_ENTRIES - 1) ? '0 : fp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tlbt_pkg::ST_LOOK && !hit_s1) begin
			tag_q[fp_q] <= page_s1;
			if (pm_valid_s1)
				tgt_q[fp_q] <= pm_frame_s1;
			else
				tgt_q[fp_q] <= full ? lru_frame : used_q[FRAME_W-1:0];
		end
	end

	// Stage 3: read the touched frame's rank
	always_ff @(posedge clk) begin
		if (state_q == tlbt_pkg::ST_RANK)
			rank_s3 <= rank_v[frame_s2];
	end

	// Advance the used-frame count on a fresh frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			used_q <= '0;
		else if (commit && push_s2)
			used_q <= used_q + 1'b1;
	end

	// Broadcast the recency update
	always_comb begin
		cmd.push  = commit && push_s2;
		cmd.touch = commit && !push_s2;
		cmd.own   = commit && ev_s2;
		cmd.frame = tlbt_pkg::CMD_FRAME_W'(frame_s2);
		cmd.rank  = tlbt_pkg::CMD_FRAME_W'(rank_s3);
		cmd.page  = tlbt_pkg::CMD_PAGE_W'(page_s1);
		cmd.used  = tlbt_pkg::CMD_USED_W'(used_q);
	end

	for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
		tlbt_rank_cell #(
			.INDEX  (g),
			.FRAME_W(FRAME_W),
			.PAGE_W (PAGE_W)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.rank  (rank_v[g]),
			.owner (owner_v[g])
		);
	end

	// Result register
	assign phys_wide = (32'(frame_s2) << OFFSET_BITS) | 32'(offset_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit)
			out_data_q <= {5'b0,
				ev_s2 ? tlbt_pkg::OUT_PG_W'(ev_page_s2) : tlbt_pkg::OUT_PG_W'(0),
				ev_s2, fault_s2, hit_s1,
				phys_wide[tlbt_pkg::VA_W-1:0],
				tlbt_pkg::OUT_FR_W'(frame_s2)};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
	a_ev_needs_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[25])
		else $error("eviction without page fault");
	a_hit_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24] |-> !m_axis_tdata[25])
		else $error("TLB hit reported as fault");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= 32'(MAX_FRAMES))
		else $error("frame count overrun");
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tlbt_pkg::ST_LOOK && !hit_s1 && !pm_valid_s1 && !full
		|=> push_s2)
		else $error("free frame not handed out");
`endif

endmodule

[tb/tlb_lru_page_translator_test.sv]
`timescale 1ns / 1ps
// Testbench for tlb_lru_page_translator: drives address words and frame-count
// writes, predicts each translation in a local TLB/LRU model. Depends on tlbt_pkg.
module tlb_lru_page_translator_test;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 12;

	typedef struct packed {
		logic [7:0]  ev_page;
		logic        ev_valid;
		logic        fault;
		logic        hit;
		logic [15:0] phys;
		logic [7:0]  frame;
	} xlate_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [tlbt_pkg::NUMFR_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [tlbt_pkg::VA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [tlbt_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	// Local copy of translator state
	logic [8:0]  frame_limit;
	logic        pm_valid [256];
	logic [7:0]  pm_frame [256];
	logic [7:0]  owner [256];
	int unsigned rank [256];
	logic [7:0]  tag [16];
	logic [7:0]  target [16];
	logic        live [16];
	int unsigned fill_ptr;
	int unsigned used_count;

	xlate_t pending_xlate [$];
	int errors = 0;
	int idle_cycles = 0;

	tlb_lru_page_translator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void clear_model();
		frame_limit = 9'd256;
		for (int i = 0; i < 256; i++) begin
			pm_valid[i] = 1'b0; pm_frame[i] = '0; owner[i] = '0; rank[i] = 0;
		end
		for (int i = 0; i < 16; i++) begin
			tag[i] = '0; target[i] = '0; live[i] = 1'b0;
		end
		fill_ptr = 0;
		used_count = 0;
	endfunction

	// Move a frame to most recently used
	function automatic void touch(int unsigned f);
		int unsigned r;
		r = rank[f];
		for (int unsigned g = 0; g < used_count; g++)
			if (rank[g] < r) rank[g]++;
		rank[f] = 0;
	endfunction

	function automatic xlate_t translate(logic [15:0] va);
		xlate_t x;
		int unsigned page, lim, frame, best;
		logic hit;
		page = 32'(va[15:8]);
		lim = 32'(frame_limit);
		if (lim < tlbt_pkg::MIN_FRAMES) lim = tlbt_pkg::MIN_FRAMES;
		if (lim > 256) lim = 256;
		hit = 1'b0;
		frame = 0;
		x = '0;
		for (int i = 0; i < 16; i++)
			if (!hit && live[i] && 32'(tag[i]) == page) begin
				hit = 1'b1; frame = 32'(target[i]);
			end
		if (hit) begin
			touch(frame);
		end else begin
			if (pm_valid[page]) begin
				frame = 32'(pm_frame[page]);
				touch(frame);
			end else begin
				x.fault = 1'b1;
				if (used_count >= lim) begin
					best = 0;
					for (int unsigned g = 1; g < used_count; g++)
						if (rank[g] > rank[best]) best = g;
					frame = best;
					x.ev_valid = 1'b1;
					x.ev_page = owner[frame];
					pm_valid[owner[frame]] = 1'b0;
					for (int i = 0; i < 16; i++)
						if (live[i] && tag[i] == owner[frame]) live[i] = 1'b0;
					touch(frame);
				end else begin
					frame = used_count;
					for (int unsigned g = 0; g < used_count; g++) rank[g]++;
					rank[frame] = 0;
					used_count++;
				end
				owner[frame] = page[7:0];
				pm_valid[page] = 1'b1;
				pm_frame[page] = frame[7:0];
			end
			tag[fill_ptr] = page[7:0];
			target[fill_ptr] = frame[7:0];
			live[fill_ptr] = 1'b1;
			fill_ptr = (fill_ptr + 1) % 16;
		end
		x.hit = hit;
		x.frame = frame[7:0];
		x.phys = {frame[7:0], va[7:0]};
		return x;
	endfunction

	// Send one address word after a random gap; valid stays up for a zero gap
	task automatic send_address(logic [15:0] va);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= va;
		do @(posedge clk); while (!s_axis_tready);
		pending_xlate.push_back(translate(va));
	endtask

	// Drop input valid after the last word of a run
	task automatic stop_input();
		s_axis_tvalid <= 1'b0;
	endtask

	// Wait for all results, then write the frame count
	task automatic set_frame_limit(logic [8:0] value);
		stop_input();
		while (pending_xlate.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		frame_limit = value;
	endtask

	// Random output stall per word
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		xlate_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[34:0];
			if (pending_xlate.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = pending_xlate.pop_front();
				if (got.frame !== want.frame)
					$display("%0t: frame exp %h got %h", $time, want.frame, got.frame);
				if (got.phys !== want.phys)
					$display("%0t: phys exp %h got %h", $time, want.phys, got.phys);
				if (got.hit !== want.hit)
					$display("%0t: hit exp %b got %b", $time, want.hit, got.hit);
				if (got.fault !== want.fault)
					$display("%0t: fault exp %b got %b", $time, want.fault, got.fault);
				if (got.ev_valid !== want.ev_valid)
					$display("%0t: evict exp %b got %b", $time, want.ev_valid, got.ev_valid);
				if (got.ev_page !== want.ev_page)
					$display("%0t: evpage exp %h got %h", $time, want.ev_page, got.ev_page);
				if (got !== want || m_axis_tdata[39:35] !== 5'd0) errors++;
			end
		end
	end

	// Watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic test_directed();
		send_address(16'h0000);
		send_address(16'hFFFF);
		send_address(16'h00FF);
		send_address(16'hFF00);
		send_address(16'h0000);
		send_address(16'hA55A);
		send_address(16'h5AA5);
		send_address(16'hFF80);
	endtask

	// Low limit with many pages: constant eviction, TLB invalidation
	task automatic test_eviction(int n, int span);
		for (int i = 0; i < n; i++)
			send_address({8'($urandom_range(0, span)), 8'($urandom)});
	endtask

	// Sweep pages so frames fill, then revisit for LRU order
	task automatic test_sweep(int first, int count);
		for (int i = 0; i < count; i++)
			send_address({8'(first + i), 8'($urandom)});
		for (int i = count - 1; i >= 0; i -= 3)
			send_address({8'(first + i), 8'($urandom)});
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 2) == 0)
				send_address(16'($urandom));
			else
				send_address({8'($urandom_range(0, 40)), 8'($urandom)});
		end
	endtask

	initial begin
		clear_model();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		set_frame_limit(9'd0);
		test_sweep(16, 20);
		test_eviction(150, 30);
		set_frame_limit(9'd511);
		test_random(200);
		set_frame_limit(9'd16);
		test_eviction(150, 24);
		set_frame_limit(9'd40);
		test_random(200);
		set_frame_limit(9'd256);
		test_random(150);
		set_frame_limit(9'd17);
		test_eviction(60, 255);
		stop_input();
		while (pending_xlate.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

[sim.f]
sv/tlbt_pkg.sv
sv/tlbt_rank_cell.sv
sv/tlb_lru_page_translator.sv
tb/tlb_lru_page_translator_test.sv
